// ----- design/bsc_pkg.sv -----
`default_nettype none
package bsc_pkg;
   localparam int CordicSteps = 16;
   localparam int Steps = (CordicSteps > 32) ? 32 : CordicSteps;
   localparam int CW = 52;

   typedef logic [CW-1:0] vec_type;

   typedef struct packed {
      logic           valid;
      logic           none;
      logic signed [CW-1:0] bu;
      logic signed [CW-1:0] bv;
      logic [31:0]    ba;
      logic           bz;
      logic signed [CW-1:0] hu;
      logic signed [CW-1:0] hv;
      logic [31:0]    ha;
      logic           hz;
   } stage_type;

   localparam logic [2:0] DIR_NONE   = 3'd0;
   localparam logic [2:0] DIR_AHEAD  = 3'd1;
   localparam logic [2:0] DIR_BEHIND = 3'd2;
   localparam logic [2:0] DIR_SIDE_A = 3'd3;
   localparam logic [2:0] DIR_SIDE_B = 3'd4;

   localparam logic signed [31:0] NoTargetLimit = -32'sd130678784;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] t [32];
      t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
            32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
            32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
            32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
      return t[i];
   endfunction
endpackage
`default_nettype wire

// ----- design/bsc_if.sv -----
`default_nettype none
interface bsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_height;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   modport source (output valid, target_x, target_y, target_height, position_x,
      position_y, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, target_x, target_y, target_height, position_x,
      position_y, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface bsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] direction;
   modport source (output valid, direction, input ready);
   modport sink (input valid, direction, output ready);
endinterface
`default_nettype wire

// ----- design/bearing_sector_classifier_unit.sv -----
`default_nettype none
// A request passes the front stages, then the registered CORDIC steps, then the output register.
// Throughput: one transaction per cycle while the response is not stalled.
// A stalled response halts the whole pipeline in place, with nothing lost or repeated.
// Reset is synchronous and active high and clears all valid bits; data is not reset.
module bearing_sector_classifier_unit (
   input wire logic clock,
   input wire logic reset,
   bsc_req_if.sink   req,
   bsc_rsp_if.source rsp
);
   localparam int N = bsc_pkg::Steps;
   bsc_pkg::stage_type pipe [N+1];
   logic advance;
   logic out_valid_ff;
   logic [2:0] dir_ff, dir_in;
   logic [15:0] b16, h16, bear, head;
   logic [31:0] br, hr;
   logic signed [17:0] d, ad;

   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   bsc_front u_front (
      .clock, .reset, .advance, .in_valid(req.valid),
      .target_x(req.target_x), .target_y(req.target_y),
      .target_height(req.target_height),
      .position_x(req.position_x), .position_y(req.position_y),
      .quat_x(req.quat_x), .quat_y(req.quat_y), .quat_z(req.quat_z),
      .quat_w(req.quat_w), .out(pipe[0])
   );

   for (genvar g = 0; g < N; g++) begin : g_step
      bsc_cordic_stage u_step (
         .clock, .reset, .advance, .step(5'(g)), .in(pipe[g]), .out(pipe[g+1])
      );
   end

   always_comb begin
      br = pipe[N].ba + 32'h8000;
      hr = pipe[N].ha + 32'h8000;
      b16 = pipe[N].bz ? 16'h0 : br[31:16];
      h16 = pipe[N].hz ? 16'h0 : hr[31:16];
      bear = 16'h0 - b16;
      head = 16'h8000 - h16;
      d = 18'($signed({2'b00, head})) - 18'($signed({2'b00, bear}));
      ad = d[17] ? -d : d;
      if (pipe[N].none) begin
         dir_in = bsc_pkg::DIR_NONE;
      end else if (ad < 18'sd8192) begin
         dir_in = bsc_pkg::DIR_AHEAD;
      end else if (ad > 18'sd24576) begin
         dir_in = bsc_pkg::DIR_BEHIND;
      end else if (d > 18'sd8192 && d < 18'sd24576) begin
         dir_in = bsc_pkg::DIR_SIDE_A;
      end else begin
         dir_in = bsc_pkg::DIR_SIDE_B;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= pipe[N].valid;
      end
      if (advance) begin
         dir_ff <= dir_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.direction = dir_ff;

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.ready && rsp.valid |-> !req.ready) else $error("ready while stalled");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.direction <= bsc_pkg::DIR_SIDE_B) else $error("bad code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(dir_ff)) else $error("output moved in stall");
`endif
endmodule
`default_nettype wire

// ----- design/bsc_front.sv -----
`default_nettype none
// Two stages: differences and quaternion products, then scaling and prerotation.
module bsc_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  wire logic signed [31:0] target_x,
   input  wire logic signed [31:0] target_y,
   input  wire logic signed [31:0] target_height,
   input  wire logic signed [31:0] position_x,
   input  wire logic signed [31:0] position_y,
   input  wire logic signed [15:0] quat_x,
   input  wire logic signed [15:0] quat_y,
   input  wire logic signed [15:0] quat_z,
   input  wire logic signed [15:0] quat_w,
   output bsc_pkg::stage_type out
);
   logic v1_ff, none1_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [31:0] yx_ff, zw_ff, yy_ff, ww_ff;
   bsc_pkg::stage_type st_ff, st_in;
   logic signed [33:0] num, den;
   logic signed [bsc_pkg::CW-1:0] bu, bv, hu, hv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         st_ff.valid <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         st_ff.valid <= v1_ff;
      end
      if (advance) begin
         none1_ff <= (target_height <= bsc_pkg::NoTargetLimit);
         dx_ff <= 33'(target_x) - 33'(position_x);
         dy_ff <= 33'(target_y) - 33'(position_y);
         yx_ff <= quat_y * quat_x;
         zw_ff <= quat_z * quat_w;
         yy_ff <= quat_y * quat_y;
         ww_ff <= quat_w * quat_w;
         st_ff.none <= st_in.none;
         st_ff.bu <= st_in.bu;
         st_ff.bv <= st_in.bv;
         st_ff.ba <= st_in.ba;
         st_ff.bz <= st_in.bz;
         st_ff.hu <= st_in.hu;
         st_ff.hv <= st_in.hv;
         st_ff.ha <= st_in.ha;
         st_ff.hz <= st_in.hz;
      end
   end

   always_comb begin
      num = (34'(yx_ff) - 34'(zw_ff)) <<< 1;
      den = 34'sh10000000 - ((34'(yy_ff) + 34'(ww_ff)) <<< 1);
      bu = bsc_pkg::CW'(dx_ff) <<< 8;
      bv = bsc_pkg::CW'(dy_ff) <<< 8;
      hu = bsc_pkg::CW'(den) <<< 8;
      hv = bsc_pkg::CW'(num) <<< 8;
      st_in = '0;
      st_in.none = none1_ff;
      st_in.bz = (dx_ff == '0) && (dy_ff == '0);
      st_in.hz = (num == '0) && (den == '0);
      st_in.bu = bu[bsc_pkg::CW-1] ? -bu : bu;
      st_in.bv = bu[bsc_pkg::CW-1] ? -bv : bv;
      st_in.ba = bu[bsc_pkg::CW-1] ? 32'h80000000 : 32'h0;
      st_in.hu = hu[bsc_pkg::CW-1] ? -hu : hu;
      st_in.hv = hu[bsc_pkg::CW-1] ? -hv : hv;
      st_in.ha = hu[bsc_pkg::CW-1] ? 32'h80000000 : 32'h0;
   end

   assign out = st_ff;
endmodule
`default_nettype wire

// ----- design/bsc_cordic_stage.sv -----
`default_nettype none
module bsc_cordic_stage (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic [4:0] step,
   input  bsc_pkg::stage_type in,
   output bsc_pkg::stage_type out
);
   bsc_pkg::stage_type st_ff, st_in;
   logic [31:0] t;

   always_comb begin
      t = bsc_pkg::atan_turn(int'(step));
      st_in = in;
      if (in.bv > 0) begin
         st_in.bu = in.bu + (in.bv >>> step);
         st_in.bv = in.bv - (in.bu >>> step);
         st_in.ba = in.ba + t;
      end else begin
         st_in.bu = in.bu - (in.bv >>> step);
         st_in.bv = in.bv + (in.bu >>> step);
         st_in.ba = in.ba - t;
      end
      if (in.hv > 0) begin
         st_in.hu = in.hu + (in.hv >>> step);
         st_in.hv = in.hv - (in.hu >>> step);
         st_in.ha = in.ha + t;
      end else begin
         st_in.hu = in.hu - (in.hv >>> step);
         st_in.hv = in.hv + (in.hu >>> step);
         st_in.ha = in.ha - t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (advance) begin
         st_ff.valid <= in.valid;
      end
      if (advance) begin
         st_ff.none <= st_in.none;
         st_ff.bu <= st_in.bu;
         st_ff.bv <= st_in.bv;
         st_ff.ba <= st_in.ba;
         st_ff.bz <= st_in.bz;
         st_ff.hu <= st_in.hu;
         st_ff.hv <= st_in.hv;
         st_ff.ha <= st_in.ha;
         st_ff.hz <= st_in.hz;
      end
   end

   assign out = st_ff;
endmodule
`default_nettype wire

// ----- bench/bearing_sector_classifier_unit_checker.sv -----
`timescale 1ns / 1ps
module bearing_sector_classifier_unit_checker (
   input wire logic clock,
   input wire logic reset,
   bsc_req_if.sink  req_mon,
   bsc_rsp_if.sink  rsp_mon,
   output int       fail_count,
   output int       pending_count,
   output int       rsp_count
);
   localparam int NumSteps = (bsc_pkg::CordicSteps > 32) ? 32 : bsc_pkg::CordicSteps;
   localparam longint HeightFloor = -1994 * 65536;

   logic [2:0] direction_queue[$];
   int hist[5];

   initial begin
      fail_count = 0;
      rsp_count = 0;
      for (int k = 0; k < 5; k++) begin
         hist[k] = 0;
      end
   end

   assign pending_count = direction_queue.size();

   function automatic logic [15:0] angle_turns(input longint v_in, input longint u_in);
      logic [31:0] ang;
      longint u;
      longint v;
      longint du;
      longint dv;
      ang = 32'd0;
      u = u_in;
      v = v_in;
      if (u == 0 && v == 0) begin
         return 16'd0;
      end
      u = u * 256;
      v = v * 256;
      if (u < 0) begin
         u = -u;
         v = -v;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < NumSteps; i++) begin
         du = v >>> i;
         dv = u >>> i;
         if (v > 0) begin
            u = u + du;
            v = v - dv;
            ang = ang + bsc_pkg::atan_turn(i);
         end else begin
            u = u - du;
            v = v + dv;
            ang = ang - bsc_pkg::atan_turn(i);
         end
      end
      ang = ang + 32'h8000;
      return ang[31:16];
   endfunction

   function automatic logic [2:0] sector_of(
      input longint tx, input longint ty, input longint th, input longint px,
      input longint py, input longint qx, input longint qy, input longint qz,
      input longint qw);
      logic [15:0] bearing;
      logic [15:0] heading;
      int d;
      int ad;
      if (th <= HeightFloor) begin
         return bsc_pkg::DIR_NONE;
      end
      bearing = 16'd0 - angle_turns(ty - py, tx - px);
      heading = 16'd32768 - angle_turns(2 * (qy * qx - qz * qw),
                                        (64'sd1 <<< 28) - 2 * (qy * qy + qw * qw));
      d = int'(heading) - int'(bearing);
      ad = (d < 0) ? -d : d;
      if (ad < 8192) begin
         return bsc_pkg::DIR_AHEAD;
      end else if (ad > 24576) begin
         return bsc_pkg::DIR_BEHIND;
      end else if (d > 8192 && d < 24576) begin
         return bsc_pkg::DIR_SIDE_A;
      end
      return bsc_pkg::DIR_SIDE_B;
   endfunction

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [2:0] exp_dir;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            direction_queue.push_back(sector_of(req_mon.target_x, req_mon.target_y,
               req_mon.target_height, req_mon.position_x, req_mon.position_y,
               req_mon.quat_x, req_mon.quat_y, req_mon.quat_z, req_mon.quat_w));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_count++;
            if (direction_queue.size() == 0) begin
               report($sformatf("unexpected transaction, direction %0d", rsp_mon.direction));
            end else begin
               exp_dir = direction_queue.pop_front();
               if (exp_dir <= 4) begin
                  hist[exp_dir]++;
               end
               if (rsp_mon.direction !== exp_dir) begin
                  report($sformatf("direction %0d, expected %0d", rsp_mon.direction,
                     exp_dir));
               end
            end
         end
      end
   end

   task automatic summarize();
      $display("Covered %0d responses; codes none/ahead/behind/sideA/sideB: %0d %0d %0d %0d %0d",
         rsp_count, hist[0], hist[1], hist[2], hist[3], hist[4]);
      if (direction_queue.size() != 0) begin
         report($sformatf("%0d expected transactions never arrived",
            direction_queue.size()));
      end
   endtask
endmodule

// ----- bench/bearing_sector_classifier_unit_tb.sv -----
`timescale 1ns / 1ps
module bearing_sector_classifier_unit_tb;
   logic clock;
   logic reset;
   int fail_count;
   int pending_count;
   int rsp_count;
   bit calm;

   bsc_req_if req_bus ();
   bsc_rsp_if rsp_bus ();

   bearing_sector_classifier_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   bearing_sector_classifier_unit_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("Timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh8000_0000 + $urandom_range(0, 3);
         2: return 32'sh7fff_ffff - $urandom_range(0, 3);
         3: return $urandom_range(0, 1) ? 32'd0 : 32'(-$urandom_range(0, 4));
         default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
      endcase
   endfunction

   function automatic logic [15:0] pick_quat();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic send(input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] th,
                       input logic [31:0] px, input logic [31:0] py, input logic [15:0] qx,
                       input logic [15:0] qy, input logic [15:0] qz, input logic [15:0] qw);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.target_x <= tx;
      req_bus.target_y <= ty;
      req_bus.target_height <= th;
      req_bus.position_x <= px;
      req_bus.position_y <= py;
      req_bus.quat_x <= qx;
      req_bus.quat_y <= qy;
      req_bus.quat_z <= qz;
      req_bus.quat_w <= qw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [31:0] th;
      case ($urandom_range(0, 7))
         0: th = 32'(-1994 * 65536) - $urandom_range(0, 2);
         1: th = 32'(-1994 * 65536) + $urandom_range(1, 2);
         2: th = $urandom;
         default: th = $urandom_range(0, 1000 << 16);
      endcase
      send(pick_pos(), pick_pos(), th, pick_pos(), pick_pos(), pick_quat(), pick_quat(),
           pick_quat(), pick_quat());
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 14) - 1) @(negedge clock);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      int wait_cycles;
      calm = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.target_x = '0;
      req_bus.target_y = '0;
      req_bus.target_height = '0;
      req_bus.position_x = '0;
      req_bus.position_y = '0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.quat_w = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(1 << 16, 0, 0, 0, 0, 0, 0, 0, 0);
      send(0, 1 << 16, 0, 0, 0, 0, 0, 0, 16384);
      send(-(1 << 16), 0, 0, 0, 0, 0, 0, 0, 16384);
      send(0, -(1 << 16), 32'(-1994 * 65536), 0, 0, 0, 0, 0, 16384);
      send(0, -(1 << 16), 32'(-1994 * 65536) + 1, 0, 0, 0, 0, 0, 16384);
      send(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
           16384, 16384, 16384, 16384);
      send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
           -16384, -16384, -16384, -16384);
      send(32'sh8000_0000, 32'sh7fff_ffff, 5, 32'sh7fff_ffff, 32'sh8000_0000,
           16384, -16384, 16384, -16384);
      send(1 << 16, -1, 0, 0, 0, 0, 16384, 0, 0);
      send(1 << 16, 1, 0, 0, 0, 0, 0, 0, 0);
      send(-1, -1, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send(-(1 << 16), 1, 0, 0, 0, 11585, 0, 0, 11585);
      send(1 << 16, 1 << 16, 0, 0, 0, 0, 0, 11585, 11585);
      send(1 << 16, -(1 << 16), 0, 0, 0, 0, 11585, 0, 11585);

      for (int n = 0; n < 985; n++) begin
         if (n == 400) begin
            req_bus.valid <= 1'b0;
            wait_cycles = 0;
            while (pending_count != 0 && wait_cycles < 20000) begin
               @(negedge clock);
               wait_cycles++;
            end
         end
         if (n == 850) calm = 1'b1;
         send_random();
      end
      req_bus.valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (40) @(negedge clock);

      checker_inst.summarize();
      @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
